@@ src/b64e_pkg.sv @@
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the symbol-to-character mapping of the
// streaming base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [6:0] PAD_CHAR   = 7'h3D;  // '='
   localparam logic [6:0] PLUS_CHAR  = 7'h2B;  // '+'
   localparam logic [6:0] SLASH_CHAR = 7'h2F;  // '/'

   // group phase codes
   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;

   // one byte's worth of output work: up to two symbols, then padding
   typedef struct packed {
      logic [5:0] sym0;
      logic [5:0] sym1;
      logic       two_syms;  // sym1 is a real symbol, not padding
      logic [2:0] count;     // characters to emit, 1..4
      logic       last;      // final character ends the message
   } job_type;

   // standard alphabet A-Z a-z 0-9 + /
   function automatic logic [6:0] sym_to_char(input logic [5:0] sym);
      logic [6:0] ch;
      if (sym < 6'd26) begin
         ch = {1'b0, sym} + 7'd65;
      end else if (sym < 6'd52) begin
         ch = {1'b0, sym} + 7'd71;
      end else if (sym < 6'd62) begin
         ch = {1'b0, sym} - 7'd4;
      end else if (sym == 6'd62) begin
         ch = PLUS_CHAR;
      end else begin
         ch = SLASH_CHAR;
      end
      return ch;
   endfunction

endpackage

@@ src/base64_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet, with '=' padding on the
// final byte of a message.
// ----------------------------------------------------------------------------
// One byte enters per req beat (tlast marks the final byte) and leaves as one
// to four ASCII characters on rsp, one character per cycle while rsp_tready
// is high; tlast marks the last character of a message. A byte gives one
// character in group phases 0 and 1, two in phase 2, and four (phase 0) or
// three (phase 1) when it ends a message in that phase. A four-job queue sits
// between byte intake and character emission, so bytes keep arriving while a
// character waits on rsp_tready. An accepted byte passes through the queue
// and then the output register before its first character appears. An empty
// message gives no output.
module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // is_final
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic       rsp_tlast    // end_of_message
);

   b64e_pkg::job_type push_job, head_job;
   logic              push_valid, push_ready;
   logic              head_valid, head_pop;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (head_valid),
      .pop        (head_pop),
      .pop_job    (head_job)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (head_valid),
      .job        (head_job),
      .pop        (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // a pending job always reaches the output register when it is free
   a_job_drains: assert property (@(posedge clock) disable iff (reset)
      (head_valid && (!rsp_tvalid || rsp_tready)) |=> rsp_tvalid)
      else $error("queued job not moved to output register");

   // padding runs without gaps up to the end of the message
   a_pad_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast &&
       rsp_tdata[6:0] == b64e_pkg::PAD_CHAR)
      |=> (rsp_tvalid && rsp_tdata[6:0] == b64e_pkg::PAD_CHAR))
      else $error("padding not followed by padding");

   // a job is popped only together with a load of its last character
   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> (head_valid && (!rsp_tvalid || rsp_tready)))
      else $error("job popped without output load");
`endif

endmodule

@@ src/b64e_front.sv @@
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, tracks the group phase and leftover bits, and
// turns each byte into a job for the character emitter.
// ----------------------------------------------------------------------------
module b64e_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] in_byte
   input  logic               req_tlast,   // is_final
   output logic               push_valid,
   input  logic               push_ready,
   output b64e_pkg::job_type  push_job
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic       accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   always_comb begin
      push_job      = '0;
      push_job.last = req_tlast;
      phase_in      = phase_ff;
      left_in       = left_ff;
      case (phase_ff)
         b64e_pkg::PHASE_1: begin
            push_job.sym0     = {left_ff[1:0], req_tdata[7:4]};
            push_job.sym1     = {req_tdata[3:0], 2'b00};
            push_job.two_syms = req_tlast;
            push_job.count    = req_tlast ? 3'd3 : 3'd1;
            phase_in          = b64e_pkg::PHASE_2;
            left_in           = req_tdata[3:0];
         end
         b64e_pkg::PHASE_2: begin
            push_job.sym0     = {left_ff, req_tdata[7:6]};
            push_job.sym1     = req_tdata[5:0];
            push_job.two_syms = 1'b1;
            push_job.count    = 3'd2;
            phase_in          = b64e_pkg::PHASE_0;
            left_in           = 4'd0;
         end
         default: begin
            push_job.sym0     = req_tdata[7:2];
            push_job.sym1     = {req_tdata[1:0], 4'b0000};
            push_job.two_syms = req_tlast;
            push_job.count    = req_tlast ? 3'd4 : 3'd1;
            phase_in          = b64e_pkg::PHASE_1;
            left_in           = {2'b00, req_tdata[1:0]};
         end
      endcase
      // end of message: back to the start of a group
      if (req_tlast) begin
         phase_in = b64e_pkg::PHASE_0;
         left_in  = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PHASE_0;
         left_ff  <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

@@ src/b64e_queue.sv @@
// ----------------------------------------------------------------------------
// b64e_queue
// Small job queue between the byte front end and the character emitter.
// ----------------------------------------------------------------------------
module b64e_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  b64e_pkg::job_type  push_job,
   output logic               pop_valid,
   input  logic               pop,
   output b64e_pkg::job_type  pop_job
);

   b64e_pkg::job_type entry_ff [b64e_pkg::QUEUE_DEPTH];

   logic [b64e_pkg::QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [b64e_pkg::QUEUE_AW:0]   count_ff;
   logic                          do_push, do_pop;

   assign push_ready = (count_ff != (b64e_pkg::QUEUE_AW+1)'(b64e_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ src/b64e_back.sv @@
// ----------------------------------------------------------------------------
// b64e_back
// Walks the characters of the head job into the output register, one per
// cycle unless rsp_tready stalls, and pops the job with its last character.
// ----------------------------------------------------------------------------
module b64e_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  b64e_pkg::job_type  job,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // [6:0] out_char, [7] zero
   output logic               rsp_tlast    // end_of_message
);

   logic [1:0] idx_ff;
   logic       valid_ff;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load, job_done;

   assign load     = job_valid && (!valid_ff || rsp_tready);
   assign job_done = ({1'b0, idx_ff} == (job.count - 3'd1));
   assign pop      = load && job_done;

   always_comb begin
      if (idx_ff == 2'd0) begin
         char_in = b64e_pkg::sym_to_char(job.sym0);
      end else if (idx_ff == 2'd1 && job.two_syms) begin
         char_in = b64e_pkg::sym_to_char(job.sym1);
      end else begin
         char_in = b64e_pkg::PAD_CHAR;
      end
      last_in = job_done && job.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= job_done ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // hold the payload while the beat stalls
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, char_ff};
   assign rsp_tlast  = last_ff;

endmodule
